[hw/rtl/kpd_pkg.sv]
package kpd_pkg;

  localparam int RowsDef = 4;
  localparam int ColsDef = 3;

  // fixed widths of the words on the ports
  localparam int RowLevelsW = 4;
  localparam int KeyStatesW = 24;
  localparam int DriveColW  = 2;
  localparam int CfgW       = 8;
  localparam int PaddrW     = 3;
  localparam int PdataW     = 32;

  localparam logic [CfgW-1:0] TickStepRst   = 8'd1;
  localparam logic [CfgW-1:0] ScanPeriodRst = 8'd10;

  // register select, taken from paddr bit 2
  typedef enum logic {
    REG_TICK_STEP   = 1'b0,
    REG_SCAN_PERIOD = 1'b1
  } reg_sel_e;

  typedef enum logic [1:0] {
    PH_RELEASED     = 2'd0,
    PH_PRE_PRESSED  = 2'd1,
    PH_PRESSED      = 2'd2,
    PH_PRE_RELEASED = 2'd3
  } key_phase_e;

  localparam logic LvlPressed  = 1'b0;
  localparam logic LvlReleased = 1'b1;

  function automatic key_phase_e next_phase(key_phase_e ph, logic a, logic b);
    logic both_low;
    logic both_high;
    key_phase_e nx;
    both_low  = (a == LvlPressed) && (b == LvlPressed);
    both_high = (a == LvlReleased) && (b == LvlReleased);
    case (ph)
      PH_RELEASED:     nx = both_low ? PH_PRE_PRESSED : PH_RELEASED;
      PH_PRE_PRESSED:  nx = both_low ? PH_PRESSED : PH_PRE_PRESSED;
      PH_PRESSED:      nx = both_high ? PH_PRE_RELEASED : PH_PRESSED;
      PH_PRE_RELEASED: nx = both_high ? PH_RELEASED : PH_PRE_RELEASED;
      default:         nx = PH_RELEASED;
    endcase
    return nx;
  endfunction

endpackage

[hw/rtl/kpd_scan_timer.sv]
module kpd_scan_timer import kpd_pkg::*; #(
  parameter int COLS = ColsDef,
  localparam int ColW = (COLS > 1) ? $clog2(COLS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tick_i,
  input  logic [CfgW-1:0] tick_step_i,
  input  logic [CfgW-1:0] scan_period_i,
  output logic            scan_o,
  output logic [ColW-1:0] col_o,
  output logic [ColW-1:0] col_next_o
);

  logic [CfgW-1:0] count_q, count_d;
  logic [CfgW-1:0] sum;
  logic [ColW-1:0] col_q, col_d;
  logic [ColW-1:0] col_adv;

  assign sum    = count_q + tick_step_i;
  assign scan_o = (sum == scan_period_i);

  // wrap after the last column, also from any index out of range
  assign col_adv = (col_q >= ColW'(COLS - 1)) ? '0 : col_q + ColW'(1);

  always_comb begin
    count_d = count_q;
    col_d   = col_q;
    if (tick_i) begin
      count_d = scan_o ? '0 : sum;
      if (scan_o) begin
        col_d = col_adv;
      end
    end
  end

  assign col_o      = col_q;
  assign col_next_o = col_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      col_q   <= '0;
    end else begin
      count_q <= count_d;
      col_q   <= col_d;
    end
  end

endmodule

[hw/rtl/kpd_debounce.sv]
module kpd_debounce import kpd_pkg::*; #(
  parameter int ROWS = RowsDef,
  parameter int COLS = ColsDef,
  localparam int ColW = (COLS > 1) ? $clog2(COLS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  scan_i,
  input  logic [ColW-1:0]       col_i,
  input  logic [RowLevelsW-1:0] row_levels_i,
  output logic [KeyStatesW-1:0] key_states_o
);

  localparam int NKeys    = ROWS * COLS;
  localparam int NOutKeys = KeyStatesW / 2;

  logic       older_q [NKeys];
  logic       newer_q [NKeys];
  key_phase_e phase_q [NKeys];
  logic       older_d [NKeys];
  logic       newer_d [NKeys];
  key_phase_e phase_d [NKeys];

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    logic lvl;
    // rows beyond the pins read as released
    if (r < RowLevelsW) begin : g_pin
      assign lvl = row_levels_i[r];
    end else begin : g_nopin
      assign lvl = LvlReleased;
    end
    for (genvar c = 0; c < COLS; c++) begin : g_col
      localparam int K = r * COLS + c;
      logic hit;
      assign hit = scan_i && (col_i == ColW'(c));

      always_comb begin
        older_d[K] = older_q[K];
        newer_d[K] = newer_q[K];
        phase_d[K] = phase_q[K];
        if (hit) begin
          older_d[K] = newer_q[K];
          newer_d[K] = lvl;
          phase_d[K] = next_phase(phase_q[K], newer_q[K], lvl);
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          older_q[K] <= LvlReleased;
          newer_q[K] <= LvlReleased;
          phase_q[K] <= PH_RELEASED;
        end else begin
          older_q[K] <= older_d[K];
          newer_q[K] <= newer_d[K];
          phase_q[K] <= phase_d[K];
        end
      end
    end
  end

  // packed view of the updated phases, keys past the word are dropped
  for (genvar k = 0; k < NOutKeys; k++) begin : g_pack
    if (k < NKeys) begin : g_key
      assign key_states_o[2*k +: 2] = phase_d[k];
    end else begin : g_none
      assign key_states_o[2*k +: 2] = 2'b00;
    end
  end

endmodule

[hw/rtl/keypad_scan_debounce.sv]
// Matrix keypad scanner with per-key debounce, ROWS x COLS keys (4 x 3 by
// default). Each accepted input word is one system tick carrying the row pin
// levels (0 = pressed); every tick gives exactly one output word, registered,
// at a rate of one word per cycle while out_ready is held high. The 8-bit
// tick counter adds tick_step each tick; when the sum equals scan_period the
// counter clears, the current column is sampled, every key in it steps its
// four-state debounce machine, and the column index advances. Rows above the
// four pins read as released and only the first twelve keys appear in
// key_states (two bits per key, key = row*COLS + column). Registers: tick_step
// at address 0 (reset 1), scan_period at address 4 (reset 10); write them
// only while no word is in flight.
module keypad_scan_debounce import kpd_pkg::*; #(
  parameter int ROWS = RowsDef,
  parameter int COLS = ColsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrW-1:0]     paddr,
  input  logic [PdataW-1:0]     pwdata,
  output logic [PdataW-1:0]     prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [RowLevelsW-1:0] row_levels_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DriveColW-1:0]  drive_column_o,
  output logic                  drive_enable_o,
  output logic                  scanned_o,
  output logic [KeyStatesW-1:0] key_states_o
);

  localparam int ColW = (COLS > 1) ? $clog2(COLS) : 1;

  logic [CfgW-1:0] tick_step_q, scan_period_q;
  logic            cfg_wr;
  reg_sel_e        sel;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign sel    = reg_sel_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_step_q   <= TickStepRst;
      scan_period_q <= ScanPeriodRst;
    end else if (cfg_wr) begin
      case (sel)
        REG_TICK_STEP:   tick_step_q   <= pwdata[CfgW-1:0];
        REG_SCAN_PERIOD: scan_period_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_TICK_STEP:   prdata = PdataW'(tick_step_q);
      REG_SCAN_PERIOD: prdata = PdataW'(scan_period_q);
      default:         prdata = '0;
    endcase
  end

  // output register takes a new word whenever it is empty or being drained
  logic tick;
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign tick       = in_valid_i && in_ready_o;

  logic            scan_raw;
  logic            scan;
  logic [ColW-1:0] col, col_next;
  logic [KeyStatesW-1:0] key_states;

  kpd_scan_timer #(.COLS(COLS)) u_timer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick),
    .tick_step_i   (tick_step_q),
    .scan_period_i (scan_period_q),
    .scan_o        (scan_raw),
    .col_o         (col),
    .col_next_o    (col_next)
  );

  assign scan = tick && scan_raw;

  kpd_debounce #(.ROWS(ROWS), .COLS(COLS)) u_debounce (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scan_i       (scan),
    .col_i        (col),
    .row_levels_i (row_levels_i),
    .key_states_o (key_states)
  );

  logic                 out_valid_q, out_valid_d;
  logic [DriveColW-1:0] drive_column_q;
  logic                 drive_enable_q;
  logic                 scanned_q;
  logic [KeyStatesW-1:0] key_states_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (tick) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      drive_column_q <= DriveColW'(col_next);
      drive_enable_q <= !scan_raw;
      scanned_q      <= scan_raw;
      key_states_q   <= key_states;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_column_o = drive_column_q;
  assign drive_enable_o = drive_enable_q;
  assign scanned_o      = scanned_q;
  assign key_states_o   = key_states_q;

endmodule

[verif/testbench.sv]
module testbench;
  import kpd_pkg::*;

  localparam int KeyRows    = RowsDef;
  localparam int KeyCols    = ColsDef;
  localparam int KeyCount   = KeyRows * KeyCols;
  localparam int CycleLimit = 200000;
  localparam int MaxPrinted = 40;
  localparam int LongHold   = 80;

  typedef struct packed {
    logic [DriveColW-1:0]  column;
    logic                  enable;
    logic                  scanned;
    logic [KeyStatesW-1:0] states;
  } scan_word_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [PaddrW-1:0]     paddr        = '0;
  logic [PdataW-1:0]     pwdata       = '0;
  logic [PdataW-1:0]     prdata;
  logic                  pready;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [RowLevelsW-1:0] row_levels_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [DriveColW-1:0]  drive_column_o;
  logic                  drive_enable_o;
  logic                  scanned_o;
  logic [KeyStatesW-1:0] key_states_o;

  // scanner state as the predictor sees it
  logic [CfgW-1:0]       step_cfg   = TickStepRst;
  logic [CfgW-1:0]       period_cfg = ScanPeriodRst;
  logic [CfgW-1:0]       tick_sum   = '0;
  logic [DriveColW-1:0]  col_sel    = '0;
  logic                  hist_old [KeyCount];
  logic                  hist_new [KeyCount];
  key_phase_e            phase    [KeyCount];

  logic [RowLevelsW-1:0] pending_rows [$];
  scan_word_t            words_due    [$];
  int unsigned           mismatch_count = 0;
  int unsigned           cycle_count    = 0;
  logic                  long_hold_req  = 1'b0;
  logic                  long_hold_done = 1'b0;
  int                    burst_left = 0;
  int                    gap_left   = 0;
  int                    hold_left  = 0;
  int                    mode_left  = 0;
  int                    stall_mode = 0;
  logic [7:0]            stall_pattern = 8'b1011_0010;

  keypad_scan_debounce i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .row_levels_i   (row_levels_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_column_o (drive_column_o),
    .drive_enable_o (drive_enable_o),
    .scanned_o      (scanned_o),
    .key_states_o   (key_states_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    for (int k = 0; k < KeyCount; k++) begin
      hist_old[k] = LvlReleased;
      hist_new[k] = LvlReleased;
      phase[k]    = PH_RELEASED;
    end
  end

  // a key only moves when its last two samples agree
  function automatic key_phase_e debounce_step(key_phase_e ph, logic older, logic newer);
    if (older != newer) return ph;
    if (newer == LvlPressed) begin
      if (ph == PH_RELEASED) return PH_PRE_PRESSED;
      if (ph == PH_PRE_PRESSED) return PH_PRESSED;
    end else begin
      if (ph == PH_PRESSED) return PH_PRE_RELEASED;
      if (ph == PH_PRE_RELEASED) return PH_RELEASED;
    end
    return ph;
  endfunction

  function automatic scan_word_t scan_tick(logic [RowLevelsW-1:0] rows);
    scan_word_t w;
    logic       hit;
    int         k;
    tick_sum = tick_sum + step_cfg;
    hit = (tick_sum == period_cfg);
    if (hit) begin
      tick_sum = '0;
      for (int r = 0; r < KeyRows; r++) begin
        k = r * KeyCols + col_sel;
        hist_old[k] = hist_new[k];
        hist_new[k] = (r < RowLevelsW) ? rows[r] : LvlReleased;
        phase[k] = debounce_step(phase[k], hist_old[k], hist_new[k]);
      end
      col_sel = (col_sel + 1 >= KeyCols) ? '0 : col_sel + 1'b1;
    end
    w.column  = col_sel;
    w.enable  = !hit;
    w.scanned = hit;
    w.states  = '0;
    for (int j = 0; j < KeyCount && j < KeyStatesW / 2; j++) w.states[2*j +: 2] = phase[j];
    return w;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted)
      $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want, cycle_count);
  endtask

  // writes both registers and reads them back
  task automatic program_scan(logic [CfgW-1:0] step, logic [CfgW-1:0] period);
    logic [CfgW-1:0] value;
    reg_sel_e        sel;
    for (int i = 0; i < 2; i++) begin
      sel   = (i == 0) ? REG_TICK_STEP : REG_SCAN_PERIOD;
      value = (i == 0) ? step : period;
      @(posedge clk_i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PaddrW'({sel, 2'b00});
      pwdata  <= PdataW'(value);
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (sel == REG_TICK_STEP) step_cfg = value;
      else period_cfg = value;
      @(posedge clk_i);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      @(negedge clk_i);
      if (prdata !== PdataW'(value)) report_mismatch("register read", prdata, value);
      @(posedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_rows.size() != 0 || in_valid_i || words_due.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  // mostly held row patterns so keys get through the debounce, some noise
  task automatic queue_key_activity(int n);
    int              left;
    int              run;
    logic [RowLevelsW-1:0] pat;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 1) != 0) pat = RowLevelsW'($urandom);
        else pat = 4'hF & ~(4'h1 << $urandom_range(0, 3));
        run = $urandom_range(3, 30);
      end else begin
        pat = '0;
        run = $urandom_range(1, 6);
      end
      if (run > left) run = left;
      for (int i = 0; i < run; i++)
        pending_rows.push_back((pat == '0) ? RowLevelsW'($urandom) : pat);
      left -= run;
    end
  endtask

  initial begin
    logic [RowLevelsW-1:0] corner_rows [10];
    int unsigned           set_step   [9];
    int unsigned           set_period [9];
    int unsigned           set_items  [9];
    corner_rows = '{4'h0, 4'hF, 4'h1, 4'h2, 4'h4, 4'h8, 4'hE, 4'hD, 4'hB, 4'h0};
    set_step    = '{1, 0, 255,   3,   1, 255,   2, 2, 1};
    set_period  = '{1, 0, 255,   3, 255,   1,   0, 7, 1};
    set_items   = '{180, 60, 150, 120, 260, 60, 150, 40, 60};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one scan on the tenth tick
    foreach (corner_rows[i]) pending_rows.push_back(corner_rows[i]);
    wait_drained();

    // scan every tick: press all keys, then release them all
    program_scan(8'd1, 8'd1);
    repeat (6) pending_rows.push_back(4'h0);
    repeat (6) pending_rows.push_back(4'hF);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      program_scan(CfgW'(set_step[p]), CfgW'(set_period[p]));
      if (p == 0) long_hold_req = 1'b1;
      queue_key_activity(set_items[p]);
      wait_drained();
    end
    for (int p = 0; p < 3; p++) begin
      program_scan(CfgW'($urandom_range(0, 255)), CfgW'($urandom_range(0, 255)));
      queue_key_activity(50);
      wait_drained();
    end

    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // sender: bursts of words with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      row_levels_i <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_rows.size() != 0) begin
        in_valid_i   <= 1'b1;
        row_levels_i <= pending_rows.pop_front();
        burst_left--;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall modes that change now and then, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (long_hold_req && !long_hold_done) begin
        hold_left      = LongHold;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(16, 64);
        end
        mode_left--;
        case (stall_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) != 0);
          default: begin
            out_ready_i   <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    scan_word_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (words_due.size() == 0) begin
          report_mismatch("word with nothing expected", key_states_o, 0);
        end else begin
          want = words_due.pop_front();
          if (drive_column_o !== want.column)
            report_mismatch("drive_column", drive_column_o, want.column);
          if (drive_enable_o !== want.enable)
            report_mismatch("drive_enable", drive_enable_o, want.enable);
          if (scanned_o !== want.scanned)
            report_mismatch("scanned", scanned_o, want.scanned);
          if (key_states_o !== want.states)
            report_mismatch("key_states", key_states_o, want.states);
        end
      end
      if (in_valid_i && in_ready_o) words_due.push_back(scan_tick(row_levels_i));
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
